// File: rtl/varm_pkg.sv
`default_nettype none

package varm_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // Internal unit vectors, cosine and sine are Q30 values.
  localparam int QF = 30;
  // Result bits of each square root and each quotient, one bit per stage.
  localparam int QB = QF + 1;

  // Entry pairs (i,j) of the symmetric k*k^T product, in storage order.
  localparam int KK_I [6] = '{0, 0, 0, 1, 1, 2};
  localparam int KK_J [6] = '{0, 1, 2, 1, 2, 2};

endpackage

`default_nettype wire

// File: rtl/vector_align_rotation_matrix.sv
`default_nettype none

// Rotation matrix that carries the vector to rotate onto the base vector.
// Input channel: one item holds base_x/y/z and rot_x/y/z, signed fixed point
// with FRAC_BITS fraction bits. Result channel: one item holds the nine
// entries m00..m22 of the 3x3 Rodrigues matrix in the same format, plus a
// degenerate flag in out_tuser (parallel vectors, or a zero-length input).
// Every input item gives exactly one result item, in order.
// The pipeline takes one item per cycle while out_tready stays high: the
// vector-length and sine square roots and the nine normalizing divisions
// are unrolled one result bit per stage, in 93 stages.
// Each stage has its own valid bit and moves whenever it is empty or the
// stage after it moves, so bubbles close up while the receiver stalls and
// in_tready falls only once every stage holds an item.
// Synchronous reset (rst_n low) empties the pipeline; no result is pending
// after reset.
module vector_align_rotation_matrix
  import varm_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int IN_W      = ((6 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W     = ((9 * DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // base_x, base_y, base_z, rot_x, rot_y, rot_z
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [OUT_W-1:0]      out_tdata,
  // degenerate
  output logic                  out_tuser
);

  localparam int DW = DATA_WIDTH;
  localparam int VW = 2 * DW + 2;
  localparam int VE = VW + 32;
  localparam int PW = $clog2(VW);
  localparam int SH = QF - FRAC_BITS;

  localparam int S_IN  = 0;
  localparam int S_MUL = 1;
  localparam int S_CR  = 2;
  localparam int S_OR  = 3;
  localparam int S_LZ  = 4;
  localparam int S_SH  = 5;
  localparam int S_SQ  = 6;
  localparam int S_SUM = 7;
  localparam int S_RT0 = 8;
  localparam int S_DV0 = S_RT0 + QB;
  localparam int S_U   = S_DV0 + QB;
  localparam int S_DOT = S_U + 1;
  localparam int S_C   = S_DOT + 1;
  localparam int S_CC  = S_C + 1;
  localparam int S_D   = S_CC + 1;
  localparam int S_ST0 = S_D + 1;
  localparam int S_KK  = S_ST0 + QB;
  localparam int S_KT  = S_KK + 1;
  localparam int S_ACC = S_KT + 1;
  localparam int S_OUT = S_ACC + 1;
  localparam int NST   = S_OUT + 1;

  localparam logic signed [37:0] RND  = 38'((64'd1 << SH) >> 1);
  localparam logic signed [37:0] SHI  = (38'sd1 <<< (DW - 1)) - 38'sd1;
  localparam logic signed [37:0] SLO  = -(38'sd1 <<< (DW - 1));
  localparam logic signed [35:0] ONE36 = 36'sd1 <<< QF;

  // Arithmetic shift that brings the largest magnitude to bit 29.
  function automatic logic signed [31:0] norm_shift(logic signed [VW-1:0] x,
                                                    logic [PW-1:0] p);
    logic signed [VE-1:0] xe;
    logic signed [VE-1:0] y;
    xe = VE'(x);
    if (p > PW'(QF - 1)) begin
      y = xe >>> (p - PW'(QF - 1));
    end else begin
      y = xe <<< (PW'(QF - 1) - p);
    end
    return y[31:0];
  endfunction

  // Round a Q30 value to FRAC_BITS and saturate to the output range.
  function automatic logic [DW-1:0] emit(logic signed [35:0] x);
    logic signed [37:0] y;
    y = (38'(x) + RND) >>> SH;
    if (y > SHI) begin
      y = SHI;
    end else if (y < SLO) begin
      y = SLO;
    end
    return y[DW-1:0];
  endfunction

  // Stage valid bits and the per-stage advance chain.
  logic [NST-1:0] v_r;
  logic [NST:0]   en;

  assign en[NST] = out_tready;
  for (genvar s = 0; s < NST; s++) begin : g_en
    assign en[s] = !v_r[s] || en[s+1];
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int s = 1; s < NST; s++) begin
        if (en[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  // Flags {parallel, zero length} travel from the cross product to the end.
  logic [1:0] fl_r [S_CR:S_OUT-1];

  // Input, cross products, normalization front end.
  logic signed [DW-1:0]   b0_r [3];
  logic signed [DW-1:0]   r0_r [3];
  logic signed [DW-1:0]   b1_r [3];
  logic signed [DW-1:0]   r1_r [3];
  logic signed [2*DW-1:0] p1_r [6];
  logic                   zr1_r;
  logic signed [VW-1:0]   v2_r [3][3];
  logic signed [VW-1:0]   v3_r [3][3];
  logic [VW-1:0]          mo3_r [3];
  logic signed [VW-1:0]   v4_r [3][3];
  logic [PW-1:0]          lp4_r [3];
  logic [PW-1:0]          lp_c [3];
  logic signed [31:0]     w5_r [3][3];
  logic signed [31:0]     w6_r [3][3];
  logic [60:0]            sq6_r [3][3];
  logic signed [31:0]     w7_r [3][3];
  logic [61:0]            sm7_r [3];

  logic signed [VW-1:0] cr_c [3];
  logic [VW-1:0]        mg_c [3][3];

  always_comb begin
    cr_c[0] = VW'(p1_r[0]) - VW'(p1_r[1]);
    cr_c[1] = VW'(p1_r[2]) - VW'(p1_r[3]);
    cr_c[2] = VW'(p1_r[4]) - VW'(p1_r[5]);
    for (int v = 0; v < 3; v++) begin
      for (int c = 0; c < 3; c++) begin
        mg_c[v][c] = v2_r[v][c][VW-1] ? VW'(-v2_r[v][c]) : VW'(v2_r[v][c]);
      end
    end
    for (int v = 0; v < 3; v++) begin
      lp_c[v] = '0;
      for (int b = 0; b < VW; b++) begin
        if (mo3_r[v][b]) begin
          lp_c[v] = PW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_IN]) begin
      for (int i = 0; i < 3; i++) begin
        b0_r[i] <= in_tdata[i*DW +: DW];
        r0_r[i] <= in_tdata[(3+i)*DW +: DW];
      end
    end
    if (en[S_MUL]) begin
      b1_r     <= b0_r;
      r1_r     <= r0_r;
      zr1_r    <= (b0_r[0] == '0 && b0_r[1] == '0 && b0_r[2] == '0) ||
                  (r0_r[0] == '0 && r0_r[1] == '0 && r0_r[2] == '0);
      p1_r[0]  <= r0_r[1] * b0_r[2];
      p1_r[1]  <= r0_r[2] * b0_r[1];
      p1_r[2]  <= r0_r[2] * b0_r[0];
      p1_r[3]  <= r0_r[0] * b0_r[2];
      p1_r[4]  <= r0_r[0] * b0_r[1];
      p1_r[5]  <= r0_r[1] * b0_r[0];
    end
    if (en[S_CR]) begin
      for (int i = 0; i < 3; i++) begin
        v2_r[0][i] <= VW'(b1_r[i]);
        v2_r[1][i] <= VW'(r1_r[i]);
        v2_r[2][i] <= cr_c[i];
      end
      fl_r[S_CR] <= {(cr_c[0] == '0 && cr_c[1] == '0 && cr_c[2] == '0), zr1_r};
    end
    if (en[S_OR]) begin
      v3_r <= v2_r;
      for (int v = 0; v < 3; v++) begin
        mo3_r[v] <= mg_c[v][0] | mg_c[v][1] | mg_c[v][2];
      end
    end
    if (en[S_LZ]) begin
      v4_r  <= v3_r;
      lp4_r <= lp_c;
    end
    if (en[S_SH]) begin
      for (int v = 0; v < 3; v++) begin
        for (int c = 0; c < 3; c++) begin
          w5_r[v][c] <= norm_shift(v4_r[v][c], lp4_r[v]);
        end
      end
    end
    if (en[S_SQ]) begin
      w6_r <= w5_r;
      for (int v = 0; v < 3; v++) begin
        for (int c = 0; c < 3; c++) begin
          sq6_r[v][c] <= 61'(64'(w5_r[v][c] * w5_r[v][c]));
        end
      end
    end
    if (en[S_SUM]) begin
      w7_r <= w6_r;
      for (int v = 0; v < 3; v++) begin
        sm7_r[v] <= 62'(sq6_r[v][0]) + 62'(sq6_r[v][1]) + 62'(sq6_r[v][2]);
      end
    end
    for (int s = S_CR + 1; s < S_OUT; s++) begin
      if (en[s]) begin
        fl_r[s] <= fl_r[s-1];
      end
    end
  end

  // Vector lengths: one root bit per stage.
  logic [63:0]        rt_rem_r  [3][QB];
  logic [QB-1:0]      rt_root_r [3][QB];
  logic signed [31:0] rt_w_r    [QB][3][3];

  for (genvar j = 0; j < QB; j++) begin : g_rt
    localparam int BI = QB - 1 - j;
    logic [63:0]   rem_in  [3];
    logic [QB-1:0] root_in [3];
    logic [63:0]   trial   [3];

    always_comb begin
      for (int v = 0; v < 3; v++) begin
        if (j == 0) begin
          rem_in[v]  = 64'(sm7_r[v]);
          root_in[v] = '0;
        end else begin
          rem_in[v]  = rt_rem_r[v][(j == 0) ? 0 : j-1];
          root_in[v] = rt_root_r[v][(j == 0) ? 0 : j-1];
        end
        trial[v] = (64'(root_in[v]) << (BI + 1)) + (64'd1 << (2 * BI));
      end
    end

    always_ff @(posedge clk) begin
      if (en[S_RT0 + j]) begin
        for (int v = 0; v < 3; v++) begin
          if (rem_in[v] >= trial[v]) begin
            rt_rem_r[v][j]  <= rem_in[v] - trial[v];
            rt_root_r[v][j] <= root_in[v] | (QB'(1) << BI);
          end else begin
            rt_rem_r[v][j]  <= rem_in[v];
            rt_root_r[v][j] <= root_in[v];
          end
        end
        if (j == 0) begin
          rt_w_r[j] <= w7_r;
        end else begin
          rt_w_r[j] <= rt_w_r[(j == 0) ? 0 : j-1];
        end
      end
    end
  end

  // Unit vectors: nine restoring dividers, one quotient bit per stage.
  logic [61:0]   dv_rem_r [9][QB];
  logic [QB-1:0] dv_q_r   [9][QB];
  logic          dv_sg_r  [9][QB];
  logic [QB-1:0] dv_n_r   [3][QB];

  for (genvar j = 0; j < QB; j++) begin : g_dv
    localparam int BI = QB - 1 - j;
    logic [61:0]   rem_in [9];
    logic [QB-1:0] q_in   [9];
    logic          sg_in  [9];
    logic [QB-1:0] n_in   [3];
    logic [61:0]   dcmp   [3];

    always_comb begin
      for (int v = 0; v < 3; v++) begin
        if (j == 0) begin
          n_in[v] = rt_root_r[v][QB-1];
        end else begin
          n_in[v] = dv_n_r[v][(j == 0) ? 0 : j-1];
        end
        dcmp[v] = 62'(n_in[v]) << BI;
      end
      for (int d = 0; d < 9; d++) begin
        if (j == 0) begin
          rem_in[d] = 62'($unsigned(rt_w_r[QB-1][d/3][d%3][31]
                                    ? 32'(-rt_w_r[QB-1][d/3][d%3])
                                    : 32'(rt_w_r[QB-1][d/3][d%3]))) << QF;
          q_in[d]   = '0;
          sg_in[d]  = rt_w_r[QB-1][d/3][d%3][31];
        end else begin
          rem_in[d] = dv_rem_r[d][(j == 0) ? 0 : j-1];
          q_in[d]   = dv_q_r[d][(j == 0) ? 0 : j-1];
          sg_in[d]  = dv_sg_r[d][(j == 0) ? 0 : j-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[S_DV0 + j]) begin
        for (int v = 0; v < 3; v++) begin
          dv_n_r[v][j] <= n_in[v];
        end
        for (int d = 0; d < 9; d++) begin
          dv_sg_r[d][j] <= sg_in[d];
          if (rem_in[d] >= dcmp[d/3]) begin
            dv_rem_r[d][j] <= rem_in[d] - dcmp[d/3];
            dv_q_r[d][j]   <= q_in[d] | (QB'(1) << BI);
          end else begin
            dv_rem_r[d][j] <= rem_in[d];
            dv_q_r[d][j]   <= q_in[d];
          end
        end
      end
    end
  end

  // Cosine, sine and the matrix.
  logic signed [31:0] u_r  [9];
  logic signed [63:0] dp_r [3];
  logic signed [31:0] kp_r [S_DOT:S_KK-1][3];
  logic signed [31:0] cp_r [S_C:S_ACC-1];
  logic [60:0]        cc_r;
  logic [63:0]        st_rem_r  [QB];
  logic [QB-1:0]      st_root_r [QB];
  logic signed [31:0] kk_r  [6];
  logic signed [31:0] ks_r  [3];
  logic signed [31:0] ks7_r [3];
  logic signed [35:0] kt_r  [6];
  logic signed [35:0] acc_r [9];
  logic [DW-1:0]      m_r   [9];
  logic               deg_r;

  logic signed [63:0] dsum_c;
  logic signed [33:0] cfl_c;
  logic signed [63:0] kkp_c [6];
  logic signed [63:0] ksp_c [3];
  logic signed [32:0] t_c;
  logic signed [65:0] ktp_c [6];
  logic signed [35:0] cx_c;
  logic signed [35:0] sum_c [9];

  always_comb begin
    dsum_c = dp_r[0] + dp_r[1] + dp_r[2];
    cfl_c  = dsum_c[63:QF];
    for (int i = 0; i < 6; i++) begin
      kkp_c[i] = kp_r[S_KK-1][KK_I[i]] * kp_r[S_KK-1][KK_J[i]];
    end
    for (int i = 0; i < 3; i++) begin
      ksp_c[i] = kp_r[S_KK-1][i] * $signed({1'b0, st_root_r[QB-1]});
    end
    t_c = (33'sd1 <<< QF) - 33'(cp_r[S_KT-1]);
    for (int i = 0; i < 6; i++) begin
      ktp_c[i] = kk_r[i] * t_c;
    end
    cx_c = 36'(cp_r[S_ACC-1]);
    sum_c[0] = kt_r[0] + cx_c;
    sum_c[1] = kt_r[1] - 36'(ks7_r[2]);
    sum_c[2] = kt_r[2] + 36'(ks7_r[1]);
    sum_c[3] = kt_r[1] + 36'(ks7_r[2]);
    sum_c[4] = kt_r[3] + cx_c;
    sum_c[5] = kt_r[4] - 36'(ks7_r[0]);
    sum_c[6] = kt_r[2] - 36'(ks7_r[1]);
    sum_c[7] = kt_r[4] + 36'(ks7_r[0]);
    sum_c[8] = kt_r[5] + cx_c;
  end

  always_ff @(posedge clk) begin
    if (en[S_U]) begin
      for (int d = 0; d < 9; d++) begin
        u_r[d] <= dv_sg_r[d][QB-1] ? -32'(dv_q_r[d][QB-1]) : 32'(dv_q_r[d][QB-1]);
      end
    end
    if (en[S_DOT]) begin
      for (int i = 0; i < 3; i++) begin
        dp_r[i]       <= u_r[i] * u_r[3+i];
        kp_r[S_DOT][i] <= fl_r[S_U][1] ? 32'sd0 : u_r[6+i];
      end
    end
    for (int s = S_DOT + 1; s < S_KK; s++) begin
      if (en[s]) begin
        kp_r[s] <= kp_r[s-1];
      end
    end
    if (en[S_C]) begin
      if (cfl_c > 34'sd1 <<< QF) begin
        cp_r[S_C] <= 32'sd1 <<< QF;
      end else if (cfl_c < -(34'sd1 <<< QF)) begin
        cp_r[S_C] <= -(32'sd1 <<< QF);
      end else begin
        cp_r[S_C] <= cfl_c[31:0];
      end
    end
    for (int s = S_C + 1; s < S_ACC; s++) begin
      if (en[s]) begin
        cp_r[s] <= cp_r[s-1];
      end
    end
    if (en[S_CC]) begin
      cc_r <= 61'(64'(cp_r[S_C] * cp_r[S_C]));
    end
    if (en[S_KK]) begin
      for (int i = 0; i < 6; i++) begin
        kk_r[i] <= kkp_c[i][61:QF];
      end
      for (int i = 0; i < 3; i++) begin
        ks_r[i] <= ksp_c[i][61:QF];
      end
    end
    if (en[S_KT]) begin
      ks7_r <= ks_r;
      for (int i = 0; i < 6; i++) begin
        kt_r[i] <= ktp_c[i][65:QF];
      end
    end
    if (en[S_ACC]) begin
      for (int i = 0; i < 9; i++) begin
        if (fl_r[S_KT][0]) begin
          acc_r[i] <= (i % 4 == 0) ? ONE36 : 36'sd0;
        end else begin
          acc_r[i] <= sum_c[i];
        end
      end
    end
    if (en[S_OUT]) begin
      for (int i = 0; i < 9; i++) begin
        m_r[i] <= emit(acc_r[i]);
      end
      deg_r <= fl_r[S_ACC][0] || fl_r[S_ACC][1];
    end
  end

  // Sine: root of 1 - c*c, one bit per stage.
  logic [63:0] st_d_r;

  always_ff @(posedge clk) begin
    if (en[S_D]) begin
      st_d_r <= (64'd1 << (2 * QF)) - 64'(cc_r);
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_st
    localparam int BI = QB - 1 - j;
    logic [63:0]   rem_in;
    logic [QB-1:0] root_in;
    logic [63:0]   trial;

    always_comb begin
      if (j == 0) begin
        rem_in  = st_d_r;
        root_in = '0;
      end else begin
        rem_in  = st_rem_r[(j == 0) ? 0 : j-1];
        root_in = st_root_r[(j == 0) ? 0 : j-1];
      end
      trial = (64'(root_in) << (BI + 1)) + (64'd1 << (2 * BI));
    end

    always_ff @(posedge clk) begin
      if (en[S_ST0 + j]) begin
        if (rem_in >= trial) begin
          st_rem_r[j]  <= rem_in - trial;
          st_root_r[j] <= root_in | (QB'(1) << BI);
        end else begin
          st_rem_r[j]  <= rem_in;
          st_root_r[j] <= root_in;
        end
      end
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < 9; i++) begin
      out_tdata[i*DW +: DW] = m_r[i];
    end
  end

  assign out_tuser = deg_r;

endmodule

`default_nettype wire
